/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, off while reset is active.
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    `ASSERT_PROP(label, clk, rstn, !(cond))

`endif

/* hw/rtl/cdem_pkg.sv */
// ----------------------------------------------------------------------------
// cdem_pkg
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cdem_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int OUT_BITS      = 8;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 16;
    localparam int MODE_BITS     = 2;

    localparam logic [MODE_BITS-1:0] MODE_HORZ = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_VERT = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_MAG  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAXV   = 8'd3;

    localparam logic [FW_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [FH_BITS-1:0]  HEIGHT_RESET = 16'd480;
    localparam logic [OUT_BITS-1:0] MAXV_RESET   = 8'd255;

    // Neighbor fetch selectors
    localparam logic [1:0] NB_RIGHT = 2'd0;
    localparam logic [1:0] NB_LEFT  = 2'd1;
    localparam logic [1:0] NB_DOWN  = 2'd2;
    localparam logic [1:0] NB_UP    = 2'd3;

    typedef struct packed {
        logic       take;
        logic       clear;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       sq_init;
        logic       sq_step;
        logic       emit;
    } cdem_cmd_t;

    typedef struct packed {
        logic end_frame;
        logic hold;
        logic sq_done;
        logic out_free;
    } cdem_stat_t;

endpackage

/* hw/rtl/cdem_ram.sv */
// ----------------------------------------------------------------------------
// cdem_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2050
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/cdem_datapath.sv */
// ----------------------------------------------------------------------------
// cdem_datapath
// Configuration registers, position counters, line store, gradient and
// square-root unit, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdem_datapath #(
    parameter int MAX_WIDTH  = cdem_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = cdem_pkg::PIXEL_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [cdem_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cdem_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               in_op,
    input  logic [PIXEL_BITS-1:0]              in_pixel,
    input  cdem_pkg::cdem_cmd_t                cmd,
    output cdem_pkg::cdem_stat_t               stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cdem_pkg::OUT_BITS-1:0]      out_edge,
    output logic                               out_last
);
    import cdem_pkg::*;

    localparam int DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int NB    = WB + FH_BITS;
    localparam int SW    = 2 * PIXEL_BITS + 2;
    localparam int IB    = $clog2(PIXEL_BITS + 1);
    localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

    // configuration
    logic [MODE_BITS-1:0] mode_reg;
    logic [FW_BITS-1:0]   fw_reg;
    logic [FH_BITS-1:0]   fh_reg;
    logic [OUT_BITS-1:0]  maxv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_HORZ;
            fw_reg   <= WIDTH_RESET;
            fh_reg   <= HEIGHT_RESET;
            maxv_reg <= MAXV_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MODE:   mode_reg <= cfg_data[MODE_BITS-1:0];
                CFG_WIDTH:  fw_reg   <= cfg_data[FW_BITS-1:0];
                CFG_HEIGHT: fh_reg   <= cfg_data[FH_BITS-1:0];
                CFG_MAXV:   maxv_reg <= cfg_data[OUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [WB-1:0]      w_eff;
    logic [FH_BITS-1:0] h_eff;
    logic [NB-1:0]      total_reg;

    always_comb begin
        if (fw_reg == '0) begin
            w_eff = WB'(1);
        end else if (32'(fw_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(fw_reg);
        end
        h_eff = (fh_reg == '0) ? FH_BITS'(1) : fh_reg;
    end

    always_ff @(posedge aclk) begin
        total_reg <= NB'(w_eff) * NB'(h_eff);
    end

    // positions
    logic [CB-1:0]      in_col_reg, out_col_reg;
    logic [FH_BITS-1:0] in_row_reg, out_row_reg;
    logic [NB-1:0]      n_in_reg, k_reg;
    logic [AW-1:0]      in_ptr_reg, out_ptr_reg;
    logic               complete;
    logic               wr_en;
    logic [WB:0]        in_col_inc, out_col_inc;
    logic [AW:0]        in_ptr_inc, out_ptr_inc;
    logic               last;

    assign complete    = in_row_reg >= h_eff;
    assign wr_en       = cmd.take && !in_op && !complete;
    assign in_col_inc  = (WB + 1)'(in_col_reg) + 1'b1;
    assign out_col_inc = (WB + 1)'(out_col_reg) + 1'b1;
    assign in_ptr_inc  = (AW + 1)'(in_ptr_reg) + 1'b1;
    assign out_ptr_inc = (AW + 1)'(out_ptr_reg) + 1'b1;
    assign last        = (NB + 1)'(k_reg) + 1'b1 >= (NB + 1)'(total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear || (cmd.emit && last)) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            n_in_reg    <= '0;
            in_ptr_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            k_reg       <= '0;
            out_ptr_reg <= '0;
        end else begin
            if (wr_en) begin
                n_in_reg   <= n_in_reg + 1'b1;
                in_ptr_reg <= (in_ptr_inc >= DEPTH_V) ? '0 : in_ptr_inc[AW-1:0];
                if (in_col_inc >= (WB + 1)'(w_eff)) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 1'b1;
                end else begin
                    in_col_reg <= in_col_inc[CB-1:0];
                end
            end
            if (cmd.emit) begin
                k_reg       <= k_reg + 1'b1;
                out_ptr_reg <= (out_ptr_inc >= DEPTH_V) ? '0 : out_ptr_inc[AW-1:0];
                if (out_col_inc >= (WB + 1)'(w_eff)) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_inc[CB-1:0];
                end
            end
        end
    end

    // neighbor address: step from the center pointer, wrapped into the store
    logic [WB-1:0] rd_off;
    logic          rd_back;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd_addr;

    always_comb begin
        rd_off  = '0;
        rd_back = 1'b0;
        case (cmd.rd_sel)
            NB_RIGHT: rd_off = (out_col_inc < (WB + 1)'(w_eff)) ? WB'(1) : '0;
            NB_LEFT: begin
                rd_off  = (out_col_reg != '0) ? WB'(1) : '0;
                rd_back = 1'b1;
            end
            NB_DOWN: rd_off = ((FH_BITS + 1)'(out_row_reg) + 1'b1 < (FH_BITS + 1)'(h_eff))
                              ? w_eff : '0;
            NB_UP: begin
                rd_off  = (out_row_reg != '0) ? w_eff : '0;
                rd_back = 1'b1;
            end
            default: ;
        endcase
        if (rd_back) begin
            if ((AW + 1)'(out_ptr_reg) >= (AW + 1)'(rd_off)) begin
                rd_sum = (AW + 1)'(out_ptr_reg) - (AW + 1)'(rd_off);
            end else begin
                rd_sum = (AW + 1)'(out_ptr_reg) + DEPTH_V - (AW + 1)'(rd_off);
            end
        end else begin
            rd_sum = (AW + 1)'(out_ptr_reg) + (AW + 1)'(rd_off);
            if (rd_sum >= DEPTH_V) begin
                rd_sum = rd_sum - DEPTH_V;
            end
        end
        rd_addr = rd_sum[AW-1:0];
    end

    logic [PIXEL_BITS-1:0] rd_data;

    cdem_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (in_ptr_reg),
        .wdata (in_pixel),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    logic [PIXEL_BITS-1:0] nb_reg [4];

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            nb_reg[cmd.cap_sel] <= rd_data;
        end
    end

    // gradients and digit-by-digit square root
    logic [PIXEL_BITS-1:0] gx, gy, gx_reg, gy_reg;
    logic [SW-1:0]         x_reg, q_reg, sq_bit, q_try;
    logic [IB-1:0]         cnt_reg;
    logic                  busy_reg;

    assign gx     = (nb_reg[NB_RIGHT] >= nb_reg[NB_LEFT]) ? nb_reg[NB_RIGHT] - nb_reg[NB_LEFT]
                                                         : nb_reg[NB_LEFT] - nb_reg[NB_RIGHT];
    assign gy     = (nb_reg[NB_DOWN] >= nb_reg[NB_UP]) ? nb_reg[NB_DOWN] - nb_reg[NB_UP]
                                                      : nb_reg[NB_UP] - nb_reg[NB_DOWN];
    assign sq_bit = SW'(1) << {cnt_reg, 1'b0};
    assign q_try  = q_reg + sq_bit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.sq_init) begin
            busy_reg <= 1'b1;
        end else if (cmd.sq_step && cnt_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq_init) begin
            gx_reg  <= gx;
            gy_reg  <= gy;
            x_reg   <= SW'(gx) * SW'(gx) + SW'(gy) * SW'(gy);
            q_reg   <= '0;
            cnt_reg <= IB'(PIXEL_BITS);
        end else if (cmd.sq_step) begin
            if (x_reg >= q_try) begin
                x_reg <= x_reg - q_try;
                q_reg <= (q_reg >> 1) + sq_bit;
            end else begin
                q_reg <= q_reg >> 1;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // round to nearest: remainder above q means sqrt is past q + 1/2
    logic [SW-1:0]       mag;
    logic [OUT_BITS-1:0] val;

    assign mag = q_reg + SW'(x_reg > q_reg);

    always_comb begin
        case (mode_reg)
            MODE_HORZ: val = (32'(gx_reg) > 32'd255) ? 8'd255 : OUT_BITS'(gx_reg);
            MODE_VERT: val = (32'(gy_reg) > 32'd255) ? 8'd255 : OUT_BITS'(gy_reg);
            MODE_MAG:  val = (32'(mag) > 32'(maxv_reg)) ? maxv_reg : OUT_BITS'(mag);
            default:   val = '0;
        endcase
    end

    // output register
    logic                valid_reg;
    logic [OUT_BITS-1:0] edge_reg;
    logic                last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            edge_reg <= val;
            last_reg <= last;
        end
    end

    assign out_valid = valid_reg;
    assign out_edge  = edge_reg;
    assign out_last  = last_reg;

    assign stat.end_frame = complete && (k_reg >= total_reg);
    assign stat.hold      = !complete &&
                            ((NB + 2)'(n_in_reg) <
                             (NB + 2)'(k_reg) + (NB + 2)'(w_eff) + (NB + 2)'(2));
    assign stat.sq_done   = !busy_reg;
    assign stat.out_free  = !valid_reg || out_ready;

    `ASSERT_PROP(a_ptr_range, aclk, aresetn,
                 (32'(in_ptr_reg) < DEPTH) && (32'(out_ptr_reg) < DEPTH))
    `ASSERT_PROP(a_emit_loads, aclk, aresetn, cmd.emit |=> valid_reg)
    `ASSERT_NEVER(a_emit_busy, aclk, aresetn, cmd.emit && busy_reg)

endmodule

/* hw/rtl/cdem_ctrl.sv */
// ----------------------------------------------------------------------------
// cdem_ctrl
// Sequencer: take one item, check whether a result is due, fetch the four
// neighbors, run the square root, hand the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdem_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cdem_pkg::cdem_stat_t stat,
    output cdem_pkg::cdem_cmd_t  cmd
);
    import cdem_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_RD0   = 4'd2;
    localparam logic [3:0] ST_RD1   = 4'd3;
    localparam logic [3:0] ST_RD2   = 4'd4;
    localparam logic [3:0] ST_RD3   = 4'd5;
    localparam logic [3:0] ST_RD4   = 4'd6;
    localparam logic [3:0] ST_SQI   = 4'd7;
    localparam logic [3:0] ST_SQ    = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.end_frame) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.hold) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = NB_RIGHT;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = NB_LEFT;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = NB_RIGHT;
                state_next  = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = NB_DOWN;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = NB_LEFT;
                state_next  = ST_RD3;
            end
            ST_RD3: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = NB_UP;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = NB_DOWN;
                state_next  = ST_RD4;
            end
            ST_RD4: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = NB_UP;
                state_next  = ST_SQI;
            end
            ST_SQI: begin
                cmd.sq_init = 1'b1;
                state_next  = ST_SQ;
            end
            ST_SQ: begin
                if (stat.sq_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.sq_step = 1'b1;
                end
            end
            ST_EMIT: begin
                // hold until the output register can take the item
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    `ASSERT_PROP(a_emit_free, aclk, aresetn, cmd.emit |-> stat.out_free)
    `ASSERT_PROP(a_sq_to_emit, aclk, aresetn,
                 (state_reg == ST_SQ && stat.sq_done) |=> (state_reg == ST_EMIT))
    `ASSERT_NEVER(a_step_idle, aclk, aresetn, cmd.sq_step && stat.sq_done)

endmodule

/* hw/rtl/central_difference_edge_magnitude_unit.sv */
// ----------------------------------------------------------------------------
// central_difference_edge_magnitude_unit
// Streaming central-difference edge detector with gradient magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one item per pixel in raster order (s_tuser 0) or a
//   drain tick after the frame's last pixel (s_tuser 1). Output stream m_*:
//   edge value of one pixel, m_tlast on the last pixel of the frame.
//   The result for pixel k leaves after pixel k+width+1 is taken; drain ticks
//   flush the last width+1 results.
//   Configuration channel cfg_*: register index and data, always ready;
//   write only while the block is idle.
// Processing:
//   One item is worked at a time. An item that yields no result is taken and
//   checked only; one that yields a result goes on to four neighbor reads
//   through the single line store read port and a square root that resolves
//   one result bit per cycle, then to the output register.
// Reset: positions return to the frame start, configuration registers to
//   their defaults; the line store is not cleared and needs no clearing pass.
// Stall: a result waits in the output register while the next item is
//   taken; the sequencer holds before loading a new result until it is free.
// ----------------------------------------------------------------------------
module central_difference_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = cdem_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = cdem_pkg::PIXEL_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cdem_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cdem_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]    s_tdata,   // pixel_value
    input  logic                               s_tuser,   // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cdem_pkg::OUT_BITS-1:0]      m_tdata,   // edge_value
    output logic                               m_tlast    // frame_end
);
    import cdem_pkg::*;

    cdem_cmd_t  cmd;
    cdem_stat_t stat;

    assign cfg_ready = 1'b1;

    cdem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_pixel  (s_tdata[PIXEL_BITS-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_edge  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
